// ===== hw/rtl/acck_pkg.sv =====
// ----------------------------------------------------------------------------
// acck_pkg: shared types and constants for the covered cell key unit
// Field widths, register indexes, datapath commands and the payload records
// used by the interfaces, the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package acck_pkg;

    localparam int COORD_W    = 32;
    localparam int INV_W      = 32;
    localparam int GRID_W     = 9;
    localparam int CELL_KEY_W = 24;
    localparam int WRAP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int N_AXES       = 3;
    localparam int N_CORNERS    = 6;
    localparam int CORNER_IDX_W = 3;

    // Signed 33 x 33 multiplier; the Q16.16 by Q16.16 product has 32 fraction bits.
    localparam int MUL_W      = 33;
    localparam int CELL_SHIFT = 32;

    localparam int MOD_BITS_PER_STEP = 8;
    localparam int MOD_STEPS         = COORD_W / MOD_BITS_PER_STEP;
    localparam int CTL_CNT_W         = 3;

    localparam int DEF_MAX_GRID_DIM = 256;
    localparam int DEF_MAX_SPAN     = 4;

    localparam logic [INV_W-1:0]  RST_INV_CELL_SIZE = 32'd65536;
    localparam logic [GRID_W-1:0] RST_GRID          = 9'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_CELL_SIZE = 2'd0,
        REG_GRID_X        = 2'd1,
        REG_GRID_Y        = 2'd2,
        REG_GRID_Z        = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CELL,
        OP_RANGE,
        OP_MOD_LOAD,
        OP_MOD_STEP,
        OP_MOD_DONE,
        OP_MUL_AREA,
        OP_MUL_TY,
        OP_MUL_TZ,
        OP_WALK_INIT,
        OP_WALK
    } t_dp_op;

    typedef struct packed {
        logic                    capture;
        t_dp_op                  op;
        logic [CORNER_IDX_W-1:0] cell_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic at_end;
    } t_dp_sts;

    typedef struct packed {
        logic signed [COORD_W-1:0] low_x;
        logic signed [COORD_W-1:0] low_y;
        logic signed [COORD_W-1:0] low_z;
        logic signed [COORD_W-1:0] high_x;
        logic signed [COORD_W-1:0] high_y;
        logic signed [COORD_W-1:0] high_z;
    } t_box;

    typedef struct packed {
        logic [CELL_KEY_W-1:0] cell_key;
        logic [WRAP_W-1:0]     wrap_x;
        logic [WRAP_W-1:0]     wrap_y;
        logic [WRAP_W-1:0]     wrap_z;
        logic                  last;
        logic                  clipped;
    } t_key;

endpackage

`default_nettype wire

// ===== hw/rtl/acck_box_if.sv =====
// ----------------------------------------------------------------------------
// acck_box_if: box request channel
// Valid/ready channel carrying the two corner points of one box.
// ----------------------------------------------------------------------------
`default_nettype none

interface acck_box_if import acck_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] low_x;
    logic signed [COORD_W-1:0] low_y;
    logic signed [COORD_W-1:0] low_z;
    logic signed [COORD_W-1:0] high_x;
    logic signed [COORD_W-1:0] high_y;
    logic signed [COORD_W-1:0] high_z;

    modport source (
        output valid, low_x, low_y, low_z, high_x, high_y, high_z,
        input  ready
    );

    modport sink (
        input  valid, low_x, low_y, low_z, high_x, high_y, high_z,
        output ready
    );

endinterface

`default_nettype wire

// ===== hw/rtl/acck_key_if.sv =====
// ----------------------------------------------------------------------------
// acck_key_if: cell key result channel
// Valid/ready channel carrying one covered cell key and its wrapped indices.
// ----------------------------------------------------------------------------
`default_nettype none

interface acck_key_if import acck_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CELL_KEY_W-1:0] cell_key;
    logic [WRAP_W-1:0]     wrap_x;
    logic [WRAP_W-1:0]     wrap_y;
    logic [WRAP_W-1:0]     wrap_z;
    logic                  last;
    logic                  clipped;

    modport source (
        output valid, cell_key, wrap_x, wrap_y, wrap_z, last, clipped,
        input  ready
    );

    modport sink (
        input  valid, cell_key, wrap_x, wrap_y, wrap_z, last, clipped,
        output ready
    );

endinterface

`default_nettype wire

// ===== hw/rtl/acck_controller.sv =====
// ----------------------------------------------------------------------------
// acck_controller: sequencer for the covered cell key unit
// Steps the datapath through cell index products, span clipping, the
// wrap reductions, the key term products and the cell walk.
// ----------------------------------------------------------------------------
`default_nettype none

module acck_controller import acck_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL,
        S_RANGE,
        S_MLOAD,
        S_MSTEP,
        S_MDONE,
        S_AREA,
        S_TY,
        S_TZ,
        S_INIT,
        S_WALK
    } t_state;

    t_state               r_state;
    logic [CTL_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_req_valid) begin
                        r_state <= S_CELL;
                    end
                end
                S_CELL: begin
                    if (r_cnt == CTL_CNT_W'(N_CORNERS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_RANGE;
                    end else begin
                        r_cnt <= r_cnt + CTL_CNT_W'(1);
                    end
                end
                S_RANGE: r_state <= S_MLOAD;
                S_MLOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_MSTEP;
                end
                S_MSTEP: begin
                    if (r_cnt == CTL_CNT_W'(MOD_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_MDONE;
                    end else begin
                        r_cnt <= r_cnt + CTL_CNT_W'(1);
                    end
                end
                S_MDONE: r_state <= S_AREA;
                S_AREA:  r_state <= S_TY;
                S_TY:    r_state <= S_TZ;
                S_TZ:    r_state <= S_INIT;
                S_INIT:  r_state <= S_WALK;
                S_WALK: begin
                    if (i_sts.out_free && i_sts.at_end) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A new request is taken only between boxes; the output register keeps
    // the final key of the previous box until the receiver takes it.
    assign o_req_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_NONE;
        o_cmd.capture  = (r_state == S_IDLE) && i_req_valid;
        o_cmd.cell_sel = r_cnt;
        case (r_state)
            S_CELL:  o_cmd.op = OP_CELL;
            S_RANGE: o_cmd.op = OP_RANGE;
            S_MLOAD: o_cmd.op = OP_MOD_LOAD;
            S_MSTEP: o_cmd.op = OP_MOD_STEP;
            S_MDONE: o_cmd.op = OP_MOD_DONE;
            S_AREA:  o_cmd.op = OP_MUL_AREA;
            S_TY:    o_cmd.op = OP_MUL_TY;
            S_TZ:    o_cmd.op = OP_MUL_TZ;
            S_INIT:  o_cmd.op = OP_WALK_INIT;
            S_WALK:  o_cmd.op = i_sts.out_free ? OP_WALK : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/acck_datapath.sv =====
// ----------------------------------------------------------------------------
// acck_datapath: arithmetic and storage of the covered cell key unit
// Configuration registers, corner sorting, one shared multiplier, three
// radix-256 remainder lanes, the walk counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acck_datapath import acck_pkg::*; #(
    parameter int MAX_GRID_DIM = DEF_MAX_GRID_DIM,
    parameter int MAX_SPAN     = DEF_MAX_SPAN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_box                  i_box,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_key_valid,
    input  logic                  i_key_ready,
    output t_key                  o_key
);

    localparam int DIM_W     = $clog2(MAX_GRID_DIM + 1);
    localparam int IDX_W     = $clog2(MAX_GRID_DIM);
    localparam int AREA_W    = 2 * DIM_W;
    localparam int KEY_W     = 3 * DIM_W;
    localparam int CNT_W     = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int DIM_CMP_W = 12;
    localparam int SPAN_W    = COORD_W + 2;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [INV_W-1:0]  r_inv;
    logic [GRID_W-1:0] r_grid [N_AXES];
    logic [DIM_W-1:0]  dim    [N_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= RST_INV_CELL_SIZE;
            for (int a = 0; a < N_AXES; a++) begin
                r_grid[a] <= RST_GRID;
            end
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_INV_CELL_SIZE: r_inv     <= i_cfg_data[INV_W-1:0];
                REG_GRID_X:        r_grid[0] <= i_cfg_data[GRID_W-1:0];
                REG_GRID_Y:        r_grid[1] <= i_cfg_data[GRID_W-1:0];
                REG_GRID_Z:        r_grid[2] <= i_cfg_data[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // A grid size of zero behaves as one; sizes above the maximum saturate.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [GRID_W-1:0] g);
        logic [DIM_CMP_W-1:0] gx;
        gx = DIM_CMP_W'(g);
        if (g == '0) begin
            eff_dim = DIM_W'(1);
        end else if (gx > DIM_CMP_W'(MAX_GRID_DIM)) begin
            eff_dim = DIM_W'(MAX_GRID_DIM);
        end else begin
            eff_dim = gx[DIM_W-1:0];
        end
    endfunction

    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            dim[a] = eff_dim(r_grid[a]);
        end
    end

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    // Corners 0..2 hold the per-axis minimum, 3..5 the maximum.
    logic signed [COORD_W-1:0] r_corner [N_CORNERS];
    logic signed [COORD_W-1:0] r_cell   [N_CORNERS];
    logic [CNT_W-1:0]          r_lim    [N_AXES];
    logic                      r_clip;
    logic                      r_neg    [N_AXES];
    logic [COORD_W-1:0]        r_mag    [N_AXES];
    logic [DIM_W-1:0]          r_rem    [N_AXES];
    logic [IDX_W-1:0]          r_w0     [N_AXES];
    logic [AREA_W-1:0]         r_area;
    logic [KEY_W-1:0]          r_ty0;
    logic [KEY_W-1:0]          r_tz0;
    logic [IDX_W-1:0]          r_wx, r_wy, r_wz;
    logic [KEY_W-1:0]          r_ty, r_tz;
    logic [CNT_W-1:0]          r_cx, r_cy, r_cz;
    logic                      r_out_valid;
    t_key                      r_key;

    function automatic logic signed [COORD_W-1:0] smin(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        smin = (a < b) ? a : b;
    endfunction

    function automatic logic signed [COORD_W-1:0] smax(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        smax = (a < b) ? b : a;
    endfunction

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_CELL: begin
                mul_a = MUL_W'(r_corner[i_cmd.cell_sel]);
                mul_b = $signed({1'b0, r_inv});
            end
            OP_MUL_AREA: begin
                mul_a = $signed(MUL_W'(dim[0]));
                mul_b = $signed(MUL_W'(dim[2]));
            end
            OP_MUL_TY: begin
                mul_a = $signed(MUL_W'(r_w0[1]));
                mul_b = $signed(MUL_W'(r_area));
            end
            OP_MUL_TZ: begin
                mul_a = $signed(MUL_W'(r_w0[2]));
                mul_b = $signed(MUL_W'(dim[0]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Span clipping
    // ------------------------------------------------------------------
    logic [SPAN_W-1:0] span_m1  [N_AXES];
    logic              span_cut [N_AXES];

    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            span_m1[a]  = SPAN_W'(r_cell[a + N_AXES]) - SPAN_W'(r_cell[a]);
            span_cut[a] = span_m1[a] > SPAN_W'(MAX_SPAN - 1);
        end
    end

    // ------------------------------------------------------------------
    // Remainder lanes: restoring reduction of |cell| by the grid size,
    // eight bits a cycle, one lane per axis.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   rem_nx [N_AXES];
    logic [COORD_W-1:0] mag_nx [N_AXES];
    logic [DIM_W-1:0]   wrap_fin [N_AXES];

    always_comb begin : mod_lanes
        logic [DIM_W:0]     t;
        logic [DIM_W-1:0]   rr;
        logic [COORD_W-1:0] mm;
        for (int a = 0; a < N_AXES; a++) begin
            rr = r_rem[a];
            mm = r_mag[a];
            for (int b = 0; b < MOD_BITS_PER_STEP; b++) begin
                t = {rr, mm[COORD_W-1]};
                if (t >= {1'b0, dim[a]}) begin
                    t = t - {1'b0, dim[a]};
                end
                rr = t[DIM_W-1:0];
                mm = {mm[COORD_W-2:0], 1'b0};
            end
            rem_nx[a] = rr;
            mag_nx[a] = mm;
            // A negative index with a non-zero remainder folds back into range.
            wrap_fin[a] = (r_neg[a] && (r_rem[a] != '0)) ? (dim[a] - r_rem[a]) : r_rem[a];
        end
    end

    // ------------------------------------------------------------------
    // Walk: y innermost, then z, then x; terms track y*X*Z and z*X.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] wx_inc, wy_inc, wz_inc;
    logic             x_wrap, y_wrap, z_wrap;
    logic [IDX_W-1:0] wx_nx, wy_nx, wz_nx;
    logic [KEY_W-1:0] ty_nx, tz_nx;
    logic             y_end, z_end, at_end;
    logic [KEY_W-1:0] key_sum;
    logic [KEY_W+CELL_KEY_W-1:0] key_ext;
    logic [IDX_W+WRAP_W-1:0]     wx_ext, wy_ext, wz_ext;

    always_comb begin
        wx_inc  = DIM_W'(r_wx) + DIM_W'(1);
        wy_inc  = DIM_W'(r_wy) + DIM_W'(1);
        wz_inc  = DIM_W'(r_wz) + DIM_W'(1);
        x_wrap  = (wx_inc == dim[0]);
        y_wrap  = (wy_inc == dim[1]);
        z_wrap  = (wz_inc == dim[2]);
        wx_nx   = x_wrap ? '0 : wx_inc[IDX_W-1:0];
        wy_nx   = y_wrap ? '0 : wy_inc[IDX_W-1:0];
        wz_nx   = z_wrap ? '0 : wz_inc[IDX_W-1:0];
        ty_nx   = y_wrap ? '0 : (r_ty + KEY_W'(r_area));
        tz_nx   = z_wrap ? '0 : (r_tz + KEY_W'(dim[0]));
        y_end   = (r_cy == r_lim[1]);
        z_end   = (r_cz == r_lim[2]);
        at_end  = (r_cx == r_lim[0]) && z_end && y_end;
        key_sum = r_ty + r_tz + KEY_W'(r_wx);
        key_ext = {{CELL_KEY_W{1'b0}}, key_sum};
        wx_ext  = {{WRAP_W{1'b0}}, r_wx};
        wy_ext  = {{WRAP_W{1'b0}}, r_wy};
        wz_ext  = {{WRAP_W{1'b0}}, r_wz};
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_corner[0] <= smin(i_box.low_x, i_box.high_x);
            r_corner[1] <= smin(i_box.low_y, i_box.high_y);
            r_corner[2] <= smin(i_box.low_z, i_box.high_z);
            r_corner[3] <= smax(i_box.low_x, i_box.high_x);
            r_corner[4] <= smax(i_box.low_y, i_box.high_y);
            r_corner[5] <= smax(i_box.low_z, i_box.high_z);
        end
        case (i_cmd.op)
            OP_CELL: begin
                // The low 32 integer bits of the Q34.32 product are the floored cell index.
                r_cell[i_cmd.cell_sel] <= mul_p[CELL_SHIFT+COORD_W-1:CELL_SHIFT];
            end
            OP_RANGE: begin
                for (int a = 0; a < N_AXES; a++) begin
                    r_lim[a] <= span_cut[a] ? CNT_W'(MAX_SPAN - 1) : span_m1[a][CNT_W-1:0];
                end
                r_clip <= span_cut[0] | span_cut[1] | span_cut[2];
            end
            OP_MOD_LOAD: begin
                for (int a = 0; a < N_AXES; a++) begin
                    r_neg[a] <= r_cell[a][COORD_W-1];
                    r_mag[a] <= r_cell[a][COORD_W-1] ? COORD_W'(-r_cell[a])
                                                     : COORD_W'(r_cell[a]);
                    r_rem[a] <= '0;
                end
            end
            OP_MOD_STEP: begin
                for (int a = 0; a < N_AXES; a++) begin
                    r_rem[a] <= rem_nx[a];
                    r_mag[a] <= mag_nx[a];
                end
            end
            OP_MOD_DONE: begin
                for (int a = 0; a < N_AXES; a++) begin
                    r_w0[a] <= wrap_fin[a][IDX_W-1:0];
                end
            end
            OP_MUL_AREA: r_area <= mul_p[AREA_W-1:0];
            OP_MUL_TY:   r_ty0  <= mul_p[KEY_W-1:0];
            OP_MUL_TZ:   r_tz0  <= mul_p[KEY_W-1:0];
            OP_WALK_INIT: begin
                r_wx <= r_w0[0];
                r_wy <= r_w0[1];
                r_wz <= r_w0[2];
                r_ty <= r_ty0;
                r_tz <= r_tz0;
                r_cx <= '0;
                r_cy <= '0;
                r_cz <= '0;
            end
            OP_WALK: begin
                r_key.cell_key <= key_ext[CELL_KEY_W-1:0];
                r_key.wrap_x   <= wx_ext[WRAP_W-1:0];
                r_key.wrap_y   <= wy_ext[WRAP_W-1:0];
                r_key.wrap_z   <= wz_ext[WRAP_W-1:0];
                r_key.last     <= at_end;
                r_key.clipped  <= r_clip;
                if (!y_end) begin
                    r_cy <= r_cy + CNT_W'(1);
                    r_wy <= wy_nx;
                    r_ty <= ty_nx;
                end else begin
                    r_cy <= '0;
                    r_wy <= r_w0[1];
                    r_ty <= r_ty0;
                    if (!z_end) begin
                        r_cz <= r_cz + CNT_W'(1);
                        r_wz <= wz_nx;
                        r_tz <= tz_nx;
                    end else begin
                        r_cz <= '0;
                        r_wz <= r_w0[2];
                        r_tz <= r_tz0;
                        r_cx <= r_cx + CNT_W'(1);
                        r_wx <= wx_nx;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_WALK) begin
            r_out_valid <= 1'b1;
        end else if (i_key_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_key_ready;
    assign o_sts.at_end   = at_end;
    assign o_key_valid    = r_out_valid;
    assign o_key          = r_key;

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_covered_cell_keys_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_covered_cell_keys_unit: hash grid cells covered by a box
// Turns one axis-aligned box into the keys of the grid cells it covers.
// ----------------------------------------------------------------------------
// Usage
//   i_box carries one request: two corner points in signed Q16.16. Corners may
//   come in either order on any axis. o_key returns one result per covered
//   cell, x outermost, z in the middle and y innermost, with last set on the
//   final key of the box and clipped set on every key when an axis span was
//   cut to MAX_SPAN cells.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while the
//   unit is idle; a write takes effect at once.
//   After a request is accepted, the single shared multiplier forms six cell
//   products, one a cycle; the spans are clipped, the remainder lanes reduce
//   eight bits a cycle, the multiplier forms three key term products, and then
//   one key per cycle follows while the receiver takes them. A box with N keys
//   (1 to MAX_SPAN cubed) holds the unit until its final key is loaded.
//   When the receiver stalls, the walk holds and resumes without loss; the
//   final key may wait in the output register while a new request is taken.
//   Reset returns the configuration registers and the sequencer to their reset values and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_covered_cell_keys_unit import acck_pkg::*; #(
    parameter int MAX_GRID_DIM = DEF_MAX_GRID_DIM,
    parameter int MAX_SPAN     = DEF_MAX_SPAN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    acck_box_if.sink              i_box,
    acck_key_if.source            o_key
);

    t_box    box_data;
    t_key    key_data;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    req_ready;
    logic    key_valid;

    assign box_data.low_x  = i_box.low_x;
    assign box_data.low_y  = i_box.low_y;
    assign box_data.low_z  = i_box.low_z;
    assign box_data.high_x = i_box.high_x;
    assign box_data.high_y = i_box.high_y;
    assign box_data.high_z = i_box.high_z;
    assign i_box.ready     = req_ready;

    acck_controller u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_box.valid),
        .o_req_ready (req_ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    acck_datapath #(
        .MAX_GRID_DIM (MAX_GRID_DIM),
        .MAX_SPAN     (MAX_SPAN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_box       (box_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_key_valid (key_valid),
        .i_key_ready (o_key.ready),
        .o_key       (key_data)
    );

    assign o_key.valid    = key_valid;
    assign o_key.cell_key = key_data.cell_key;
    assign o_key.wrap_x   = key_data.wrap_x;
    assign o_key.wrap_y   = key_data.wrap_y;
    assign o_key.wrap_z   = key_data.wrap_z;
    assign o_key.last     = key_data.last;
    assign o_key.clipped  = key_data.clipped;

`ifndef SYNTHESIS
    // A request starts a box; no second request is taken in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_box.valid && i_box.ready) |=> !i_box.ready)
        else $error("request accepted while a box was still being started");

    // A walk step must never overwrite a key the receiver has not taken.
    a_walk_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.op == OP_WALK) |-> (!o_key.valid || o_key.ready))
        else $error("walk step overwrote a pending key");

    // Once the final key is loaded the unit is ready for the next request.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((dp_cmd.op == OP_WALK) && dp_sts.at_end) |=> i_box.ready)
        else $error("unit not ready after the final key of a box");
`endif

endmodule

`default_nettype wire
